>>> design/mhfr_pkg.sv
package mhfr_pkg;

	localparam int          PAYLOAD_DEPTH_DEF = 32;
	localparam logic [31:0] MAGIC_RESET       = 32'hCB667C72;
	localparam logic [7:0]  ACK_RESET         = 8'h01;
	localparam logic [7:0]  CMD_INVALID       = 8'hFF;
	localparam logic [7:0]  LEN_OVERHEAD      = 8'd2;

	localparam int          CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK   = 2'd1;

	localparam logic [1:0]  ST_GOOD = 2'd0;
	localparam logic [1:0]  ST_CSUM = 2'd1;
	localparam logic [1:0]  ST_LEN  = 2'd2;

	localparam int          OUT_DATA_W = 40;

	typedef struct packed {
		logic       valid;
		logic [1:0] status;
		logic [7:0] frame_type;
		logic [7:0] command;
		logic [5:0] payload_length;
		logic       needs_ack;
		logic       last;
	} frame_ev_t;

	typedef struct packed {
		logic busy;
		logic slot_ok;
	} emit_st_t;

endpackage

>>> design/magic_header_frame_receiver.sv
// channel   | beat taken when                 | contents
// s_axis    | s_axis_tvalid & s_axis_tready   | one received byte
// m_axis    | m_axis_tvalid & m_axis_tready   | frame summary, error or payload byte
// cfg       | cfg_valid & cfg_ready           | register index and write data
//
// One received byte per cycle while parsing; no bytes are taken while a frame's
// payload plays out of the buffer memory, one payload beat per cycle while m_axis_tready is high.
// A byte that can end a frame waits for the output register to be free.
// Reset clears the parser, the output valid and the registers to defaults;
// the payload buffer needs no clearing.
module magic_header_frame_receiver #(
	parameter int PAYLOAD_DEPTH = mhfr_pkg::PAYLOAD_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,  // rx_byte
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// status, frame_type, command, payload_length, payload_byte, byte_position, needs_ack
	output logic [mhfr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output logic                               m_axis_tuser,  // is_payload
	output logic                               m_axis_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mhfr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                        cfg_data
);

	import mhfr_pkg::*;

	localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

	frame_ev_t     ev;
	emit_st_t      emit_st;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	assign cfg_ready = 1'b1;

	mhfr_parse #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH), .AW(AW)) u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.emit_st       (emit_st),
		.ev            (ev),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data)
	);

	mhfr_ram #(.WIDTH(8), .DEPTH(PAYLOAD_DEPTH), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	mhfr_emit #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH), .AW(AW)) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.ev            (ev),
		.emit_st       (emit_st),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

>>> design/mhfr_ram.sv
module mhfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/mhfr_parse.sv
module mhfr_parse #(
	parameter int PAYLOAD_DEPTH = mhfr_pkg::PAYLOAD_DEPTH_DEF,
	parameter int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,
	input  logic                            cfg_valid,
	input  logic [mhfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data,
	input  mhfr_pkg::emit_st_t              emit_st,
	output mhfr_pkg::frame_ev_t             ev,
	output logic                            wr_en,
	output logic [AW-1:0]                   wr_addr,
	output logic [7:0]                      wr_data
);

	import mhfr_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_TYPE,
		PH_LEN,
		PH_CMD,
		PH_DATA,
		PH_CSUM
	} phase_t;

	localparam logic [8:0] LEN_MAX = 9'(PAYLOAD_DEPTH + 2);

	phase_t      phase_q;
	logic [31:0] magic_q;
	logic [7:0]  ack_q;
	logic [31:0] win_q;
	logic [7:0]  sum_q;
	logic [7:0]  type_q;
	logic [7:0]  len_q;
	logic [7:0]  cmd_q;
	logic [5:0]  fill_q;

	logic [31:0] win_d;
	logic [7:0]  ch;
	logic        acc;
	logic        match;
	logic        may_emit;
	logic        len_bad;
	logic [5:0]  fill_inc;
	logic [7:0]  sum_inc;

	assign ch       = s_axis_tdata;
	assign win_d    = {win_q[23:0], ch};
	assign match    = (win_d == magic_q);
	assign may_emit = (phase_q == PH_LEN) || (phase_q == PH_CSUM);
	assign s_axis_tready = !emit_st.busy && (emit_st.slot_ok || !may_emit);
	assign acc      = s_axis_tvalid && s_axis_tready;
	assign len_bad  = ({1'b0, ch} < 9'(LEN_OVERHEAD)) || ({1'b0, ch} > LEN_MAX);
	assign fill_inc = fill_q + 6'd1;
	assign sum_inc  = sum_q + ch;

	assign wr_en   = acc && !match && (phase_q == PH_DATA)
		&& ({1'b0, fill_q} < 7'(PAYLOAD_DEPTH));
	assign wr_addr = fill_q[AW-1:0];
	assign wr_data = ch;

	always_comb begin
		ev                = '0;
		ev.frame_type     = type_q;
		if (acc && !match) begin
			if (phase_q == PH_LEN && len_bad) begin
				ev.valid  = 1'b1;
				ev.status = ST_LEN;
				ev.last   = 1'b1;
			end else if (phase_q == PH_CSUM) begin
				ev.valid          = 1'b1;
				ev.command        = cmd_q;
				ev.payload_length = fill_q;
				if (ch != sum_q) begin
					ev.status = ST_CSUM;
					ev.last   = 1'b1;
				end else begin
					ev.status    = ST_GOOD;
					ev.needs_ack = (type_q != ack_q);
					ev.last      = (fill_q == 6'd0);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			magic_q <= MAGIC_RESET;
			ack_q   <= ACK_RESET;
			win_q   <= '0;
			sum_q   <= '0;
			type_q  <= '0;
			len_q   <= '0;
			cmd_q   <= CMD_INVALID;
			fill_q  <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_MAGIC: magic_q <= cfg_data;
					CFG_ACK:   ack_q   <= cfg_data[7:0];
					default:   ;
				endcase
			end
			if (acc) begin
				win_q <= win_d;
				if (match) begin
					phase_q <= PH_TYPE;
					fill_q  <= '0;
					sum_q   <= '0;
					cmd_q   <= CMD_INVALID;
				end else begin
					unique case (phase_q)
						PH_HUNT: ;
						PH_TYPE: begin
							type_q  <= ch;
							fill_q  <= '0;
							cmd_q   <= CMD_INVALID;
							sum_q   <= ch;
							phase_q <= PH_LEN;
						end
						PH_LEN: begin
							len_q <= ch;
							if (len_bad) begin
								phase_q <= PH_HUNT;
								fill_q  <= '0;
								sum_q   <= '0;
								cmd_q   <= CMD_INVALID;
							end else begin
								sum_q   <= sum_inc;
								phase_q <= PH_CMD;
							end
						end
						PH_CMD: begin
							cmd_q   <= ch;
							sum_q   <= sum_inc;
							phase_q <= (len_q == LEN_OVERHEAD) ? PH_CSUM : PH_DATA;
						end
						PH_DATA: begin
							fill_q <= fill_inc;
							sum_q  <= sum_inc;
							if ({2'b00, fill_inc} + LEN_OVERHEAD == len_q) begin
								phase_q <= PH_CSUM;
							end
						end
						PH_CSUM: begin
							phase_q <= PH_HUNT;
							fill_q  <= '0;
							sum_q   <= '0;
							cmd_q   <= CMD_INVALID;
						end
						default: phase_q <= PH_HUNT;
					endcase
				end
			end
		end
	end

endmodule

>>> design/mhfr_emit.sv
module mhfr_emit #(
	parameter int PAYLOAD_DEPTH = mhfr_pkg::PAYLOAD_DEPTH_DEF,
	parameter int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mhfr_pkg::frame_ev_t                ev,
	output mhfr_pkg::emit_st_t                 emit_st,
	output logic [AW-1:0]                      rd_addr,
	input  logic [7:0]                         rd_data,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [mhfr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output logic                               m_axis_tuser,
	output logic                               m_axis_tlast
);

	import mhfr_pkg::*;

	logic       play_q;
	logic [5:0] idx_q;
	logic [5:0] idx_d;
	logic [5:0] n_q;
	logic [7:0] type_q;
	logic [7:0] cmd_q;
	logic       ack_q;

	logic       vld_q;
	logic [1:0] o_status_q;
	logic       o_isp_q;
	logic [7:0] o_type_q;
	logic [7:0] o_cmd_q;
	logic [5:0] o_plen_q;
	logic [7:0] o_pb_q;
	logic [4:0] o_pos_q;
	logic       o_ack_q;
	logic       o_last_q;

	logic slot_ok;
	logic play_ld;
	logic play_end;

	assign slot_ok  = !vld_q || m_axis_tready;
	assign play_ld  = play_q && slot_ok;
	assign play_end = (idx_q + 6'd1 == n_q);

	assign emit_st.busy    = play_q;
	assign emit_st.slot_ok = slot_ok;

	// address tracks the next index so rd_data always holds entry idx_q
	always_comb begin
		idx_d = idx_q;
		if (ev.valid) begin
			idx_d = '0;
		end else if (play_ld) begin
			idx_d = idx_q + 6'd1;
		end
	end
	assign rd_addr = idx_d[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_q <= 1'b0;
			idx_q  <= '0;
			vld_q  <= 1'b0;
		end else begin
			idx_q <= idx_d;
			if (ev.valid) begin
				vld_q  <= 1'b1;
				play_q <= (ev.status == ST_GOOD) && (ev.payload_length != 6'd0);
			end else if (play_ld) begin
				vld_q <= 1'b1;
				if (play_end) begin
					play_q <= 1'b0;
				end
			end else if (m_axis_tready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ev.valid) begin
			n_q        <= ev.payload_length;
			type_q     <= ev.frame_type;
			cmd_q      <= ev.command;
			ack_q      <= ev.needs_ack;
			o_status_q <= ev.status;
			o_isp_q    <= 1'b0;
			o_type_q   <= ev.frame_type;
			o_cmd_q    <= ev.command;
			o_plen_q   <= ev.payload_length;
			o_pb_q     <= '0;
			o_pos_q    <= '0;
			o_ack_q    <= ev.needs_ack;
			o_last_q   <= ev.last;
		end else if (play_ld) begin
			o_status_q <= ST_GOOD;
			o_isp_q    <= 1'b1;
			o_type_q   <= type_q;
			o_cmd_q    <= cmd_q;
			o_plen_q   <= n_q;
			o_pb_q     <= rd_data;
			o_pos_q    <= idx_q[4:0];
			o_ack_q    <= ack_q;
			o_last_q   <= play_end;
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tuser  = o_isp_q;
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tdata  = {2'b00, o_ack_q, o_pos_q, o_pb_q, o_plen_q, o_cmd_q, o_type_q,
		o_status_q};

endmodule
